// File: sv/assert_macros.svh
// Assertion macros used by the port-level checker of the deframer
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is asserted
`define RFD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset
`define RFD_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/rfd_pkg.sv
// Shared types, constants and codes of the receive deframer
package rfd_pkg;

    localparam int RingDepthDef  = 64;
    localparam int MaxPayload    = 60;
    localparam int MaxResults    = 64;
    localparam int FrameOverhead = 3;
    localparam int ByteW         = 8;
    localparam int LenW          = 6;
    localparam int KindW         = 2;
    // byte value plus frame overhead
    localparam int ExtW          = 9;
    localparam int CntW          = $clog2(MaxResults + 1);

    localparam logic [ByteW-1:0] PreambleRst = 8'd90;
    localparam logic [LenW-1:0]  MaxLenRst   = 6'd60;

    typedef enum logic [0:0] {
        CFG_PREAMBLE = 1'b0,
        CFG_MAX_LEN  = 1'b1
    } t_cfg_idx;

    typedef enum logic [KindW-1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_EMPTY   = 2'd1,
        KIND_ERROR   = 2'd2
    } t_kind;

    // ring read offset relative to the head
    typedef enum logic [1:0] {
        OFF_HEAD  = 2'd0,
        OFF_LEN   = 2'd1,
        OFF_FIRST = 2'd2,
        OFF_NEXT  = 2'd3
    } t_rd_sel;

    typedef enum logic [2:0] {
        S_IDLE   = 3'd0,
        S_HEAD   = 3'd1,
        S_HEAD_W = 3'd2,
        S_LEN    = 3'd3,
        S_SUM    = 3'd4,
        S_EMIT   = 3'd5,
        S_DONE   = 3'd6
    } t_state;

    typedef struct packed {
        t_kind            kind;
        logic [ByteW-1:0] data;
        logic [LenW-1:0]  len;
    } t_result;

    typedef struct packed {
        logic    store;
        logic    clr_cnt;
        logic    rd_en;
        t_rd_sel rd_sel;
        logic    drop_one;
        logic    drop_frame;
        logic    load_len;
        logic    sum_acc;
        logic    idx_clr;
        logic    idx_inc;
        logic    push;
        t_kind   push_kind;
        logic    zero_len;
    } t_dp_cmd;

    typedef struct packed {
        logic fill_ge3;
        logic head_is_pre;
        logic len_over;
        logic len_short;
        logic len_zero;
        logic idx_eq_len;
        logic idx_last;
        logic sum_match;
        logic cnt_full;
        logic cnt_no_room;
    } t_dp_sts;

    typedef struct packed {
        logic push;
        logic flush;
    } t_ob_cmd;

    typedef struct packed {
        logic push_ok;
        logic pend_vld;
    } t_ob_sts;

endpackage

// File: sv/rfd_ctrl.sv
// Scan controller: sequences store, header check, checksum and emission
module rfd_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  rfd_pkg::t_dp_sts i_dp_sts,
    input  rfd_pkg::t_ob_sts i_ob_sts,
    output rfd_pkg::t_dp_cmd o_dp_cmd,
    output rfd_pkg::t_ob_cmd o_ob_cmd
);

    rfd_pkg::t_state r_state;
    rfd_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rfd_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            rfd_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = rfd_pkg::S_HEAD;
                end
            end
            rfd_pkg::S_HEAD: begin
                n_state = i_dp_sts.fill_ge3 ? rfd_pkg::S_HEAD_W : rfd_pkg::S_DONE;
            end
            rfd_pkg::S_HEAD_W: begin
                n_state = i_dp_sts.head_is_pre ? rfd_pkg::S_LEN : rfd_pkg::S_HEAD;
            end
            rfd_pkg::S_LEN: begin
                if (i_dp_sts.len_over) begin
                    if (i_dp_sts.cnt_full) begin
                        n_state = rfd_pkg::S_DONE;
                    end else if (i_ob_sts.push_ok) begin
                        n_state = rfd_pkg::S_HEAD;
                    end
                end else if (i_dp_sts.len_short) begin
                    n_state = rfd_pkg::S_DONE;
                end else begin
                    n_state = rfd_pkg::S_SUM;
                end
            end
            rfd_pkg::S_SUM: begin
                if (!i_dp_sts.idx_eq_len) begin
                    n_state = rfd_pkg::S_SUM;
                end else if (i_dp_sts.sum_match) begin
                    if (i_dp_sts.cnt_no_room) begin
                        n_state = rfd_pkg::S_DONE;
                    end else if (!i_dp_sts.len_zero) begin
                        n_state = rfd_pkg::S_EMIT;
                    end else if (i_ob_sts.push_ok) begin
                        n_state = rfd_pkg::S_HEAD;
                    end
                end else if (i_dp_sts.cnt_full) begin
                    n_state = rfd_pkg::S_DONE;
                end else if (i_ob_sts.push_ok) begin
                    n_state = rfd_pkg::S_HEAD;
                end
            end
            rfd_pkg::S_EMIT: begin
                if (i_ob_sts.push_ok && i_dp_sts.idx_last) begin
                    n_state = rfd_pkg::S_HEAD;
                end
            end
            rfd_pkg::S_DONE: begin
                if (!i_ob_sts.pend_vld) begin
                    n_state = rfd_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rfd_pkg::S_IDLE;
            end
        endcase
    end

    // command outputs
    always_comb begin
        o_in_ready         = 1'b0;
        o_dp_cmd           = '0;
        o_dp_cmd.rd_sel    = rfd_pkg::OFF_HEAD;
        o_dp_cmd.push_kind = rfd_pkg::KIND_PAYLOAD;
        o_ob_cmd           = '0;
        case (r_state)
            rfd_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_dp_cmd.store   = 1'b1;
                    o_dp_cmd.clr_cnt = 1'b1;
                end
            end
            rfd_pkg::S_HEAD: begin
                if (i_dp_sts.fill_ge3) begin
                    o_dp_cmd.rd_en  = 1'b1;
                    o_dp_cmd.rd_sel = rfd_pkg::OFF_HEAD;
                end
            end
            rfd_pkg::S_HEAD_W: begin
                if (!i_dp_sts.head_is_pre) begin
                    o_dp_cmd.drop_one = 1'b1;
                end else begin
                    o_dp_cmd.rd_en  = 1'b1;
                    o_dp_cmd.rd_sel = rfd_pkg::OFF_LEN;
                end
            end
            rfd_pkg::S_LEN: begin
                if (i_dp_sts.len_over) begin
                    // over-length: error without length, drop the preamble
                    if (!i_dp_sts.cnt_full && i_ob_sts.push_ok) begin
                        o_dp_cmd.push      = 1'b1;
                        o_dp_cmd.push_kind = rfd_pkg::KIND_ERROR;
                        o_dp_cmd.zero_len  = 1'b1;
                        o_dp_cmd.drop_one  = 1'b1;
                    end
                end else if (!i_dp_sts.len_short) begin
                    o_dp_cmd.load_len = 1'b1;
                    o_dp_cmd.rd_en    = 1'b1;
                    o_dp_cmd.rd_sel   = rfd_pkg::OFF_FIRST;
                end
            end
            rfd_pkg::S_SUM: begin
                if (!i_dp_sts.idx_eq_len) begin
                    o_dp_cmd.sum_acc = 1'b1;
                    o_dp_cmd.idx_inc = 1'b1;
                    o_dp_cmd.rd_en   = 1'b1;
                    o_dp_cmd.rd_sel  = rfd_pkg::OFF_NEXT;
                end else if (i_dp_sts.sum_match) begin
                    if (!i_dp_sts.cnt_no_room) begin
                        if (!i_dp_sts.len_zero) begin
                            o_dp_cmd.idx_clr = 1'b1;
                            o_dp_cmd.rd_en   = 1'b1;
                            o_dp_cmd.rd_sel  = rfd_pkg::OFF_FIRST;
                        end else if (i_ob_sts.push_ok) begin
                            o_dp_cmd.push       = 1'b1;
                            o_dp_cmd.push_kind  = rfd_pkg::KIND_EMPTY;
                            o_dp_cmd.zero_len   = 1'b1;
                            o_dp_cmd.drop_frame = 1'b1;
                        end
                    end
                end else if (!i_dp_sts.cnt_full && i_ob_sts.push_ok) begin
                    // bad checksum: error with length, drop the preamble
                    o_dp_cmd.push      = 1'b1;
                    o_dp_cmd.push_kind = rfd_pkg::KIND_ERROR;
                    o_dp_cmd.drop_one  = 1'b1;
                end
            end
            rfd_pkg::S_EMIT: begin
                if (i_ob_sts.push_ok) begin
                    o_dp_cmd.push      = 1'b1;
                    o_dp_cmd.push_kind = rfd_pkg::KIND_PAYLOAD;
                    if (i_dp_sts.idx_last) begin
                        o_dp_cmd.drop_frame = 1'b1;
                    end else begin
                        o_dp_cmd.idx_inc = 1'b1;
                        o_dp_cmd.rd_en   = 1'b1;
                        o_dp_cmd.rd_sel  = rfd_pkg::OFF_NEXT;
                    end
                end
            end
            rfd_pkg::S_DONE: begin
                o_ob_cmd.flush = 1'b1;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
        o_ob_cmd.push = o_dp_cmd.push;
    end

endmodule

// File: sv/rfd_datapath.sv
// Datapath: ring store, head and tail indexes, length, checksum and counters
module rfd_datapath #(
    parameter int RING_DEPTH = rfd_pkg::RingDepthDef
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_wr_en,
    input  logic [0:0]                i_cfg_addr,
    input  logic [rfd_pkg::ByteW-1:0] i_cfg_wr_data,
    input  logic [rfd_pkg::ByteW-1:0] i_rx_byte,
    input  rfd_pkg::t_dp_cmd          i_cmd,
    output rfd_pkg::t_dp_sts          o_sts,
    output rfd_pkg::t_result          o_result
);

    localparam int AW = $clog2(RING_DEPTH);
    localparam int PW = AW + 1;
    localparam logic [PW-1:0] DepthP  = PW'(RING_DEPTH);
    localparam logic [AW-1:0] LastIdx = AW'(RING_DEPTH - 1);

    logic [rfd_pkg::ByteW-1:0] r_mem [RING_DEPTH];
    logic [rfd_pkg::ByteW-1:0] r_rd_data;
    logic [AW-1:0]             r_wr_idx;
    logic [AW-1:0]             r_rd_idx;
    logic [rfd_pkg::ByteW-1:0] r_preamble;
    logic [rfd_pkg::LenW-1:0]  r_max_len;
    logic [rfd_pkg::ByteW-1:0] r_len;
    logic [rfd_pkg::ByteW-1:0] r_sum;
    logic [rfd_pkg::ByteW-1:0] r_idx;
    logic [rfd_pkg::CntW-1:0]  r_cnt;

    logic [AW-1:0]             wr_next;
    logic [AW-1:0]             rd_next1;
    logic [AW-1:0]             fill;
    logic [PW-1:0]             fill_p;
    logic [rfd_pkg::ExtW-1:0]  offset;
    logic [PW-1:0]             addr_p;
    logic [AW-1:0]             rd_addr;
    logic [rfd_pkg::ExtW-1:0]  drop_amt;
    logic [PW-1:0]             drop_p;
    logic [AW-1:0]             rd_after_drop;
    logic [rfd_pkg::ByteW-1:0] limit;
    logic [rfd_pkg::ByteW-1:0] need;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_preamble <= rfd_pkg::PreambleRst;
            r_max_len  <= rfd_pkg::MaxLenRst;
        end else if (i_cfg_wr_en) begin
            case (rfd_pkg::t_cfg_idx'(i_cfg_addr))
                rfd_pkg::CFG_PREAMBLE: r_preamble <= i_cfg_wr_data;
                rfd_pkg::CFG_MAX_LEN:  r_max_len  <= i_cfg_wr_data[rfd_pkg::LenW-1:0];
                default:               r_preamble <= r_preamble;
            endcase
        end
    end

    // index arithmetic modulo the ring depth
    always_comb begin
        wr_next  = (r_wr_idx == LastIdx) ? '0 : r_wr_idx + AW'(1);
        rd_next1 = (r_rd_idx == LastIdx) ? '0 : r_rd_idx + AW'(1);

        if (r_wr_idx >= r_rd_idx) begin
            fill_p = {1'b0, r_wr_idx} - {1'b0, r_rd_idx};
        end else begin
            fill_p = {1'b0, r_wr_idx} + DepthP - {1'b0, r_rd_idx};
        end
        fill = fill_p[AW-1:0];

        case (i_cmd.rd_sel)
            rfd_pkg::OFF_HEAD:  offset = '0;
            rfd_pkg::OFF_LEN:   offset = rfd_pkg::ExtW'(1);
            rfd_pkg::OFF_FIRST: offset = rfd_pkg::ExtW'(2);
            rfd_pkg::OFF_NEXT:  offset = rfd_pkg::ExtW'(r_idx) + rfd_pkg::ExtW'(3);
            default:            offset = '0;
        endcase
        addr_p = {1'b0, r_rd_idx} + offset[PW-1:0];
        if (addr_p >= DepthP) begin
            addr_p = addr_p - DepthP;
        end
        rd_addr = addr_p[AW-1:0];

        drop_amt = i_cmd.drop_frame
                 ? rfd_pkg::ExtW'(r_len) + rfd_pkg::ExtW'(rfd_pkg::FrameOverhead)
                 : rfd_pkg::ExtW'(1);
        drop_p = {1'b0, r_rd_idx} + drop_amt[PW-1:0];
        if (drop_p >= DepthP) begin
            drop_p = drop_p - DepthP;
        end
        rd_after_drop = drop_p[AW-1:0];
    end

    // ring store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            r_mem[r_wr_idx] <= i_rx_byte;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // head and tail indexes; a full store drops its oldest byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_idx <= '0;
            r_rd_idx <= '0;
        end else if (i_cmd.store) begin
            r_wr_idx <= wr_next;
            if (wr_next == r_rd_idx) begin
                r_rd_idx <= rd_next1;
            end
        end else if (i_cmd.drop_one || i_cmd.drop_frame) begin
            r_rd_idx <= rd_after_drop;
        end
    end

    // frame length, running checksum and byte index
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_len) begin
            r_len <= r_rd_data;
            r_sum <= r_preamble ^ r_rd_data;
            r_idx <= '0;
        end else begin
            if (i_cmd.sum_acc) begin
                r_sum <= r_sum ^ r_rd_data;
            end
            if (i_cmd.idx_clr) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + rfd_pkg::ByteW'(1);
            end
        end
    end

    // results produced for the current received byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.clr_cnt) begin
            r_cnt <= '0;
        end else if (i_cmd.push) begin
            r_cnt <= r_cnt + rfd_pkg::CntW'(1);
        end
    end

    // status toward the controller
    always_comb begin
        limit = (rfd_pkg::ByteW'(r_max_len) < rfd_pkg::ByteW'(rfd_pkg::MaxPayload))
              ? rfd_pkg::ByteW'(r_max_len) : rfd_pkg::ByteW'(rfd_pkg::MaxPayload);
        need  = (r_len == '0) ? rfd_pkg::ByteW'(1) : r_len;

        o_sts.fill_ge3    = rfd_pkg::ExtW'(fill) >= rfd_pkg::ExtW'(rfd_pkg::FrameOverhead);
        o_sts.head_is_pre = r_rd_data == r_preamble;
        o_sts.len_over    = r_rd_data > limit;
        o_sts.len_short   = rfd_pkg::ExtW'(fill)
                          < rfd_pkg::ExtW'(r_rd_data) + rfd_pkg::ExtW'(rfd_pkg::FrameOverhead);
        o_sts.len_zero    = r_len == '0;
        o_sts.idx_eq_len  = r_idx == r_len;
        o_sts.idx_last    = rfd_pkg::ExtW'(r_idx) + rfd_pkg::ExtW'(1) == rfd_pkg::ExtW'(r_len);
        o_sts.sum_match   = r_sum == r_rd_data;
        o_sts.cnt_full    = rfd_pkg::ExtW'(r_cnt) >= rfd_pkg::ExtW'(rfd_pkg::MaxResults);
        o_sts.cnt_no_room = rfd_pkg::ExtW'(r_cnt) + rfd_pkg::ExtW'(need)
                          > rfd_pkg::ExtW'(rfd_pkg::MaxResults);
    end

    // result fields for the output stage
    always_comb begin
        o_result.kind = i_cmd.push_kind;
        o_result.data = (i_cmd.push_kind == rfd_pkg::KIND_PAYLOAD) ? r_rd_data : '0;
        o_result.len  = i_cmd.zero_len ? '0 : r_len[rfd_pkg::LenW-1:0];
    end

endmodule

// File: sv/rfd_out_stage.sv
// Output stage: one-deep hold-back for the last flag plus the output register
module rfd_out_stage (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  rfd_pkg::t_ob_cmd           i_cmd,
    input  rfd_pkg::t_result           i_result,
    output rfd_pkg::t_ob_sts           o_sts,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [rfd_pkg::KindW-1:0]  o_kind,
    output logic [rfd_pkg::ByteW-1:0]  o_data_byte,
    output logic [rfd_pkg::LenW-1:0]   o_frame_length,
    output logic                       o_last
);

    logic             r_pend_vld;
    rfd_pkg::t_result r_pend;
    logic             r_out_vld;
    rfd_pkg::t_result r_out;
    logic             r_out_last;
    logic             out_free;
    logic             do_push;
    logic             do_flush;

    assign out_free = !r_out_vld || i_ready;
    assign do_push  = i_cmd.push && (!r_pend_vld || out_free);
    assign do_flush = i_cmd.flush && r_pend_vld && out_free;

    // valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (do_push) begin
                r_pend_vld <= 1'b1;
            end else if (do_flush) begin
                r_pend_vld <= 1'b0;
            end
            if ((do_push && r_pend_vld) || do_flush) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload: a held result moves out once the next one or the end is known
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_pend <= i_result;
        end
        if ((do_push && r_pend_vld) || do_flush) begin
            r_out      <= r_pend;
            r_out_last <= do_flush;
        end
    end

    assign o_sts.push_ok  = !r_pend_vld || out_free;
    assign o_sts.pend_vld = r_pend_vld;

    assign o_valid        = r_out_vld;
    assign o_kind         = r_out.kind;
    assign o_data_byte    = r_out.data;
    assign o_frame_length = r_out.len;
    assign o_last         = r_out_last;

endmodule

// File: sv/rx_frame_deframer_xor_checksum_top.sv
// Sequence: store the byte, then discard head bytes that are not the preamble, read and check
//   the length (an over-length header gives an error), check the checksum, then emit a good
//   frame byte by byte; the held last result leaves at scan end when the output is not stalled.
// Throughput: one byte per scan; a bad checksum slips one byte and rechecks the next
//   header, and a new byte is not taken until the scan is done.
// Reset: synchronous active low; indexes and config return to defaults, ring contents kept.
module rx_frame_deframer_xor_checksum_top #(
    parameter int RING_DEPTH = rfd_pkg::RingDepthDef
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [0:0]                 i_cfg_addr,
    input  logic [rfd_pkg::ByteW-1:0]  i_cfg_wr_data,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [rfd_pkg::ByteW-1:0]  i_rx_byte,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [rfd_pkg::KindW-1:0]  o_kind,
    output logic [rfd_pkg::ByteW-1:0]  o_data_byte,
    output logic [rfd_pkg::LenW-1:0]   o_frame_length,
    output logic                       o_last
);

    rfd_pkg::t_dp_cmd dp_cmd;
    rfd_pkg::t_dp_sts dp_sts;
    rfd_pkg::t_ob_cmd ob_cmd;
    rfd_pkg::t_ob_sts ob_sts;
    rfd_pkg::t_result result;

    rfd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid),
        .o_in_ready (o_ready),
        .i_dp_sts   (dp_sts),
        .i_ob_sts   (ob_sts),
        .o_dp_cmd   (dp_cmd),
        .o_ob_cmd   (ob_cmd)
    );

    rfd_datapath #(
        .RING_DEPTH (RING_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_rx_byte     (i_rx_byte),
        .i_cmd         (dp_cmd),
        .o_sts         (dp_sts),
        .o_result      (result)
    );

    rfd_out_stage u_out (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (ob_cmd),
        .i_result       (result),
        .o_sts          (ob_sts),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_kind         (o_kind),
        .o_data_byte    (o_data_byte),
        .o_frame_length (o_frame_length),
        .o_last         (o_last)
    );

endmodule

// File: sv/rfd_checker.sv
// Port-level checker for the deframer, bound to the top level
`include "assert_macros.svh"

module rfd_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_valid,
    input logic                      o_ready,
    input logic                      o_valid,
    input logic                      i_ready,
    input logic [rfd_pkg::KindW-1:0] o_kind,
    input logic [rfd_pkg::ByteW-1:0] o_data_byte,
    input logic [rfd_pkg::LenW-1:0]  o_frame_length,
    input logic                      o_last
);

    // a stalled result holds
    property p_out_hold;
        o_valid && !i_ready |=> o_valid && $stable(o_kind) && $stable(o_data_byte)
            && $stable(o_frame_length) && $stable(o_last);
    endproperty

    // an accepted byte starts a scan, so the next byte waits
    property p_one_scan;
        i_valid && o_ready |=> !o_ready;
    endproperty

    // only payload results carry data
    property p_data_zero;
        o_valid && o_kind != rfd_pkg::KIND_PAYLOAD |-> o_data_byte == '0;
    endproperty

    // an empty frame reports zero length
    property p_empty_len;
        o_valid && o_kind == rfd_pkg::KIND_EMPTY |-> o_frame_length == '0;
    endproperty

    `RFD_ASSERT(a_out_hold, i_clk, i_rst_n, p_out_hold, "stalled result changed")

    // nothing is offered right after reset
    `RFD_ASSERT_RST(a_rst_quiet, i_clk, !i_rst_n |=> !o_valid, "result valid after reset")

    `RFD_ASSERT(a_one_scan, i_clk, i_rst_n, p_one_scan, "input taken during scan")

    `RFD_ASSERT(a_data_zero, i_clk, i_rst_n, p_data_zero, "data on non-payload result")

    `RFD_ASSERT(a_empty_len, i_clk, i_rst_n, p_empty_len, "empty frame with length")

endmodule

bind rx_frame_deframer_xor_checksum_top rfd_checker u_rfd_checker (.*);
